/* hdl/metropolis_sampler_step_core_assert.svh */
// Assertion macros used by the checker file of the sampler core.
`ifndef METROPOLIS_SAMPLER_STEP_CORE_ASSERT_SVH
`define METROPOLIS_SAMPLER_STEP_CORE_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define MSS_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the cycle after the antecedent.
`define MSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/mss_pkg.sv */
// Package: types, constants and the exponential table builder of the sampler.
package mss_pkg;

	localparam int EXP_TABLE_BITS_DEF = 10;

	localparam int POS_W  = 24;
	localparam int STEP_W = 23;
	localparam int IV_W   = 16;
	localparam int U_W    = 16;
	localparam int ENT_W  = 16;
	localparam int CNT_W  = 32;
	localparam int SUM_W  = 64;
	localparam int IN_W   = 32;
	localparam int OUT_W  = 224;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STEP_HALF  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_POS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_A   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_B   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_VAR_A  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INV_VAR_B  = 3'd5;

	// Reset values
	localparam logic [STEP_W-1:0]        RST_STEP_HALF = 23'd32768;
	localparam logic signed [POS_W-1:0]  RST_INIT_POS  = 24'sd655360;
	localparam logic signed [POS_W-1:0]  RST_OFFSET_A  = -24'sd327680;
	localparam logic signed [POS_W-1:0]  RST_OFFSET_B  = 24'sd327680;
	localparam logic [IV_W-1:0]          RST_INV_VAR   = 16'd4096;

	localparam logic [63:0] EXP_M1_Q32 = 64'd1580030169;

	// Term issue order
	localparam logic [1:0] TERM_PROP_A = 2'd0;
	localparam logic [1:0] TERM_PROP_B = 2'd1;
	localparam logic [1:0] TERM_CUR_A  = 2'd2;
	localparam logic [1:0] TERM_CUR_B  = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROP,
		ST_ISSUE,
		ST_DRAIN,
		ST_DECIDE,
		ST_COMMIT,
		ST_ACCUM,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic       load_in;
		logic       calc_prop;
		logic       issue;
		logic [1:0] issue_sel;
		logic       decide;
		logic       commit;
		logic       accum;
		logic       write_out;
	} cmd_t;

	typedef struct packed {
		logic terms_done;
		logic out_free;
	} status_t;

	// Table entry round(65535*exp(-16k/2^bits)), Taylor series in Q32
	function automatic logic [ENT_W-1:0] exp_entry(input int k, input int bits);
		logic [63:0] t;
		logic [63:0] n;
		logic [63:0] f;
		logic [63:0] term;
		logic [63:0] v;
		longint      sum;
		logic [63:0] r;
		t    = 64'(k) << (36 - bits);
		n    = t >> 32;
		f    = t & 64'hFFFF_FFFF;
		sum  = longint'(64'h1_0000_0000);
		term = 64'h1_0000_0000;
		for (int i = 1; i <= 24; i++) begin
			term = ((term * f) >> 32) / 64'(i);
			if ((i % 2) == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		v = 64'(sum);
		for (int j = 0; j < 16; j++) begin
			if (64'(j) < n)
				v = (v * EXP_M1_Q32 + 64'h8000_0000) >> 32;
		end
		r = (v * 64'd65535 + 64'h8000_0000) >> 32;
		return r[ENT_W-1:0];
	endfunction

endpackage

/* hdl/metropolis_sampler_step_core.sv */
// Top level: random-walk Metropolis step over a two-Gaussian density.
//
//  channel  | direction | content
//  s_*      | in        | tdata[15:0] uniform_step, tdata[31:16] uniform_test
//  m_*      | out       | position, accepted, totals and running sums
//  cfg_*    | in        | write enable, register index, data
//
// After its input word is accepted, the four density terms of a step share one
// four-stage term pipeline, then decide, commit and square accumulation follow
// before the result word is registered. The next word is taken only after the
// result word is written, so one word is in flight at a time.
// A result waiting on m_tready stalls the step in its write cycle only.
// Reset loads the configuration defaults and the start position of 10.0.
module metropolis_sampler_step_core import mss_pkg::*; #(
	parameter int EXP_TABLE_BITS = EXP_TABLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [15:0] uniform_step, [31:16] uniform_test
	input  logic [IN_W-1:0]       s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [23:0] position, [24] accepted, [56:25] accept_total, [88:57] step_total,
	// [152:89] position_sum, [216:153] square_sum, rest zero
	output logic [OUT_W-1:0]      m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t    cmd;
	status_t status;

	mss_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.status  (status),
		.cmd     (cmd)
	);

	mss_datapath #(
		.EXP_TABLE_BITS(EXP_TABLE_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_data  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

/* hdl/mss_term_unit.sv */
// Gaussian term pipeline: offset, square, scale, table lookup.
module mss_term_unit import mss_pkg::*; #(
	parameter int EXP_TABLE_BITS = EXP_TABLE_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_vld,
	input  logic                    in_tag,
	input  logic                    in_last,
	input  logic signed [POS_W-1:0] in_y,
	input  logic signed [POS_W-1:0] in_off,
	input  logic [IV_W-1:0]         in_iv,
	output logic                    out_vld,
	output logic                    out_tag,
	output logic                    out_last,
	output logic [ENT_W-1:0]        out_val
);

	localparam int DEPTH = 1 << EXP_TABLE_BITS;
	localparam int SQ_W  = 49;
	localparam int P_W   = SQ_W + IV_W;

	logic [ENT_W-1:0] rom_w [DEPTH];

	logic [2:0] vld_q;
	logic [2:0] tag_q;
	logic [2:0] last_q;
	logic       vld_s4;
	logic       tag_s4;
	logic       last_s4;

	logic signed [POS_W:0] d_w;
	logic [POS_W:0]        ad_s1;
	logic [IV_W-1:0]       iv_s1;
	logic [SQ_W-1:0]       sq_s2;
	logic [IV_W-1:0]       iv_s2;
	logic [P_W-1:0]        p_w;
	logic [EXP_TABLE_BITS-1:0] idx_s3;
	logic                  ovf_s3;
	logic [ENT_W-1:0]      val_s4;

	// Build the constant table
	for (genvar g = 0; g < DEPTH; g++) begin : g_rom
		assign rom_w[g] = exp_entry(g, EXP_TABLE_BITS);
	end

	assign d_w = $signed({in_y[POS_W-1], in_y}) + $signed({in_off[POS_W-1], in_off});
	assign p_w = P_W'(sq_s2) * P_W'(iv_s2);

	// Advance control bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			tag_q   <= '0;
			last_q  <= '0;
			vld_s4  <= 1'b0;
			tag_s4  <= 1'b0;
			last_s4 <= 1'b0;
		end else begin
			vld_q   <= {vld_q[1:0], in_vld};
			tag_q   <= {tag_q[1:0], in_tag};
			last_q  <= {last_q[1:0], in_last};
			vld_s4  <= vld_q[2];
			tag_s4  <= tag_q[2];
			last_s4 <= last_q[2];
		end
	end

	// Payload stages
	always_ff @(posedge clk) begin
		ad_s1  <= d_w[POS_W] ? (POS_W+1)'(-d_w) : (POS_W+1)'(d_w);
		iv_s1  <= in_iv;
		sq_s2  <= SQ_W'(ad_s1) * SQ_W'(ad_s1);
		iv_s2  <= iv_s1;
		ovf_s3 <= |p_w[P_W-1:SQ_W];
		idx_s3 <= p_w[SQ_W-1 -: EXP_TABLE_BITS];
		val_s4 <= ovf_s3 ? '0 : rom_w[idx_s3];
	end

	assign out_vld  = vld_s4;
	assign out_tag  = tag_s4;
	assign out_last = last_s4;
	assign out_val  = val_s4;

endmodule

/* hdl/mss_datapath.sv */
// Datapath: config registers, proposal, density sums, decision, state and output word.
module mss_datapath import mss_pkg::*; #(
	parameter int EXP_TABLE_BITS = EXP_TABLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output status_t               status,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [IN_W-1:0]       in_data,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_W-1:0]      m_tdata
);

	localparam int PROD_W = 42;
	localparam int DEN_W  = ENT_W + 1;
	localparam int CMP_W  = DEN_W + U_W;

	logic [STEP_W-1:0]        step_q;
	logic signed [POS_W-1:0]  off_a_q;
	logic signed [POS_W-1:0]  off_b_q;
	logic [IV_W-1:0]          iv_a_q;
	logic [IV_W-1:0]          iv_b_q;

	logic signed [POS_W-1:0]  cur_q;
	logic [CNT_W-1:0]         acc_cnt_q;
	logic [CNT_W-1:0]         step_cnt_q;
	logic [SUM_W-1:0]         pos_sum_q;
	logic [SUM_W-1:0]         sq_sum_q;

	logic [U_W-1:0]           us_q;
	logic [U_W-1:0]           ut_q;
	logic signed [POS_W-1:0]  prop_q;
	logic [DEN_W-1:0]         p_prop_q;
	logic [DEN_W-1:0]         p_cur_q;
	logic                     acc_q;
	logic [2*POS_W-1:0]       sq_q;

	logic                     out_vld_q;
	logic [OUT_W-1:0]         out_q;

	logic signed [17:0]       sv_w;
	logic signed [PROD_W-1:0] prod_w;
	logic signed [POS_W+2:0]  sum_w;
	logic signed [POS_W-1:0]  sat_w;
	logic signed [POS_W-1:0]  new_pos_w;
	logic [CMP_W-1:0]         lhs_w;
	logic [CMP_W-1:0]         rhs_w;

	logic                     t_vld;
	logic                     t_tag;
	logic                     t_last;
	logic signed [POS_W-1:0]  t_y;
	logic signed [POS_W-1:0]  t_off;
	logic [IV_W-1:0]          t_iv;
	logic                     r_vld;
	logic                     r_tag;
	logic                     r_last;
	logic [ENT_W-1:0]         r_val;

	// Proposal offset floor(step*(2u-65536)/65536), then saturate
	assign sv_w   = $signed({1'b0, us_q, 1'b0}) - 18'sd65536;
	assign prod_w = $signed({1'b0, step_q}) * sv_w;
	assign sum_w  = (POS_W+3)'(cur_q) + (POS_W+3)'($signed(prod_w[PROD_W-1:16]));
	always_comb begin
		if (sum_w > (POS_W+3)'(signed'(24'sh7FFFFF)))
			sat_w = 24'sh7FFFFF;
		else if (sum_w < (POS_W+3)'(signed'(24'sh800000)))
			sat_w = 24'sh800000;
		else
			sat_w = sum_w[POS_W-1:0];
	end

	// Issue one term per cycle
	always_comb begin
		t_vld  = cmd.issue;
		t_last = 1'b0;
		t_tag  = 1'b0;
		t_y    = cur_q;
		t_off  = off_a_q;
		t_iv   = iv_a_q;
		unique case (cmd.issue_sel)
			TERM_PROP_A: begin
				t_tag = 1'b1;
				t_y   = prop_q;
			end
			TERM_PROP_B: begin
				t_tag = 1'b1;
				t_y   = prop_q;
				t_off = off_b_q;
				t_iv  = iv_b_q;
			end
			TERM_CUR_A: begin
				t_tag = 1'b0;
			end
			TERM_CUR_B: begin
				t_last = 1'b1;
				t_off  = off_b_q;
				t_iv   = iv_b_q;
			end
			default: begin
				t_tag = 1'b0;
			end
		endcase
	end

	mss_term_unit #(
		.EXP_TABLE_BITS(EXP_TABLE_BITS)
	) u_term (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (t_vld),
		.in_tag  (t_tag),
		.in_last (t_last),
		.in_y    (t_y),
		.in_off  (t_off),
		.in_iv   (t_iv),
		.out_vld (r_vld),
		.out_tag (r_tag),
		.out_last(r_last),
		.out_val (r_val)
	);

	// Acceptance compare p(x')*65536 > u_test*p(x)
	assign lhs_w     = {p_prop_q, 16'b0};
	assign rhs_w     = CMP_W'(ut_q) * CMP_W'(p_cur_q);
	assign new_pos_w = acc_q ? prop_q : cur_q;

	// Hold configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= RST_STEP_HALF;
			off_a_q <= RST_OFFSET_A;
			off_b_q <= RST_OFFSET_B;
			iv_a_q  <= RST_INV_VAR;
			iv_b_q  <= RST_INV_VAR;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STEP_HALF: step_q  <= cfg_data[STEP_W-1:0];
				REG_OFFSET_A:  off_a_q <= cfg_data[POS_W-1:0];
				REG_OFFSET_B:  off_b_q <= cfg_data[POS_W-1:0];
				REG_INV_VAR_A: iv_a_q  <= cfg_data[IV_W-1:0];
				REG_INV_VAR_B: iv_b_q  <= cfg_data[IV_W-1:0];
				default: ;
			endcase
		end
	end

	// Sampler state and running totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q      <= RST_INIT_POS;
			acc_cnt_q  <= '0;
			step_cnt_q <= '0;
			pos_sum_q  <= '0;
			sq_sum_q   <= '0;
		end else begin
			if (cfg_we && cfg_index == REG_INIT_POS)
				cur_q <= cfg_data[POS_W-1:0];
			if (cmd.commit) begin
				cur_q     <= new_pos_w;
				pos_sum_q <= pos_sum_q + SUM_W'(new_pos_w);
				if (acc_q && acc_cnt_q != '1)
					acc_cnt_q <= acc_cnt_q + 1'b1;
				if (step_cnt_q != '1)
					step_cnt_q <= step_cnt_q + 1'b1;
			end
			if (cmd.accum)
				sq_sum_q <= sq_sum_q + SUM_W'(sq_q);
		end
	end

	// Per-item working registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			us_q <= in_data[U_W-1:0];
			ut_q <= in_data[2*U_W-1:U_W];
		end
		if (cmd.calc_prop) begin
			prop_q   <= sat_w;
			p_prop_q <= '0;
			p_cur_q  <= '0;
		end else if (r_vld) begin
			if (r_tag)
				p_prop_q <= p_prop_q + DEN_W'(r_val);
			else
				p_cur_q  <= p_cur_q + DEN_W'(r_val);
		end
		if (cmd.decide)
			acc_q <= lhs_w > rhs_w;
		if (cmd.commit)
			sq_q <= (2*POS_W)'(new_pos_w * new_pos_w);
	end

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (cmd.write_out)
			out_vld_q <= 1'b1;
		else if (m_tready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.write_out)
			out_q <= {7'b0, sq_sum_q, pos_sum_q, step_cnt_q, acc_cnt_q, acc_q, cur_q};
	end

	assign status.terms_done = r_vld & r_last;
	assign status.out_free   = ~out_vld_q | m_tready;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

endmodule

/* hdl/mss_ctrl.sv */
// Controller: sequences one sampler step through the datapath.
module mss_ctrl import mss_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t     state_q;
	state_t     state_d;
	logic [1:0] cnt_q;
	logic [1:0] cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_PROP;
				end
			end
			ST_PROP: begin
				cmd.calc_prop = 1'b1;
				cnt_d         = '0;
				state_d       = ST_ISSUE;
			end
			ST_ISSUE: begin
				cmd.issue     = 1'b1;
				cmd.issue_sel = cnt_q;
				cnt_d         = cnt_q + 1'b1;
				if (cnt_q == TERM_CUR_B)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (status.terms_done)
					state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = ST_COMMIT;
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = ST_ACCUM;
			end
			ST_ACCUM: begin
				cmd.accum = 1'b1;
				state_d   = ST_WRITE;
			end
			ST_WRITE: begin
				if (status.out_free) begin
					cmd.write_out = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* hdl/mss_checker.sv */
// Port-level checker for the sampler core, bound to the top level.
`include "metropolis_sampler_step_core_assert.svh"
module mss_checker import mss_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_W-1:0]      m_tdata
);

	// A stalled word holds
	`MSS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word dropped or changed under stall")
	// One word at a time: input closes right after acceptance
	`MSS_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "input taken while a step runs")
	// Accepted proposals never outnumber steps
	`MSS_ASSERT(a_acc_le_step, m_tvalid, m_tdata[56:25] <= m_tdata[88:57], "accept_total exceeds step_total")
	// A result needs a step behind it
	`MSS_ASSERT(a_step_nonzero, m_tvalid, m_tdata[88:57] != 32'd0, "result with zero step_total")

endmodule

bind metropolis_sampler_step_core mss_checker u_mss_checker (.*);

/* dv/metropolis_sampler_step_core_tb.sv */
// Testbench of the sampler core: predicted steps checked against output words.
module metropolis_sampler_step_core_tb;
	import mss_pkg::*;

	localparam int TBL_BITS = EXP_TABLE_BITS_DEF;
	localparam int WATCHDOG = 20000;

	typedef struct packed {
		logic [63:0]        sq_sum;
		logic [63:0]        pos_sum;
		logic [31:0]        steps;
		logic [31:0]        accepts;
		logic               acc;
		logic signed [23:0] pos;
	} step_word_t;

	// Predicts each step and holds the words still to come
	class step_scoreboard;
		logic [15:0]         exp_rom [1 << TBL_BITS];
		logic [22:0]         half_step;
		longint              init_pos, off_a, off_b;
		logic [15:0]         iv_a, iv_b;
		longint              cur_pos;
		logic [31:0]         acc_cnt, step_cnt;
		logic [63:0]         pos_acc, sq_acc;
		step_word_t          pending[$];
		int                  errors;

		function new();
			logic [63:0] t, n, f, term, v;
			longint      s;
			for (int k = 0; k < (1 << TBL_BITS); k++) begin
				t = 64'(k) << (36 - TBL_BITS);
				n = t >> 32;
				f = t & 64'hFFFF_FFFF;
				s = 64'h1_0000_0000;
				term = 64'h1_0000_0000;
				for (int i = 1; i <= 24; i++) begin
					term = ((term * f) >> 32) / 64'(i);
					if (i % 2) s -= longint'(term);
					else s += longint'(term);
				end
				if (s < 0) s = 0;
				v = 64'(s);
				for (longint j = 0; j < longint'(n); j++)
					v = (v * 64'd1580030169 + 64'h8000_0000) >> 32;
				exp_rom[k] = 16'((v * 64'd65535 + 64'h8000_0000) >> 32);
			end
			half_step = RST_STEP_HALF;
			init_pos = RST_INIT_POS;
			off_a = RST_OFFSET_A;
			off_b = RST_OFFSET_B;
			iv_a = RST_INV_VAR;
			iv_b = RST_INV_VAR;
			cur_pos = init_pos;
			acc_cnt = 0; step_cnt = 0; pos_acc = 0; sq_acc = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
			case (idx)
				REG_STEP_HALF: half_step = val[22:0];
				REG_INIT_POS: begin
					init_pos = longint'(signed'(val));
					cur_pos = init_pos;
				end
				REG_OFFSET_A:  off_a = longint'(signed'(val));
				REG_OFFSET_B:  off_b = longint'(signed'(val));
				REG_INV_VAR_A: iv_a = val[15:0];
				REG_INV_VAR_B: iv_b = val[15:0];
				default: ;
			endcase
		endfunction

		function logic [63:0] term_of(longint y, longint off, logic [15:0] iv);
			longint      d;
			logic [63:0] p, k;
			d = y + off;
			if (d < 0) d = -d;
			p = 64'(d) * 64'(d) * 64'(iv);
			k = p >> (49 - TBL_BITS);
			if (k >= (1 << TBL_BITS)) return 0;
			return 64'(exp_rom[k]);
		endfunction

		function logic [63:0] density_at(longint y);
			return term_of(y, off_a, iv_a) + term_of(y, off_b, iv_b);
		endfunction

		// Note an accepted input word and queue the word it should produce
		function void note_input(logic [15:0] u_step, logic [15:0] u_test);
			longint     prod, dx, prop;
			logic       acc;
			step_word_t w;
			prod = longint'(half_step) * (2 * longint'(u_step) - 65536);
			if (prod < 0) dx = -((-prod + 65535) >>> 16);
			else dx = prod >>> 16;
			prop = cur_pos + dx;
			if (prop > 8388607) prop = 8388607;
			if (prop < -8388608) prop = -8388608;
			acc = (density_at(prop) * 65536) > (64'(u_test) * density_at(cur_pos));
			if (acc) begin
				cur_pos = prop;
				if (acc_cnt != 32'hFFFF_FFFF) acc_cnt++;
			end
			if (step_cnt != 32'hFFFF_FFFF) step_cnt++;
			pos_acc += 64'(cur_pos);
			sq_acc += 64'(cur_pos * cur_pos);
			w.pos = 24'(cur_pos);
			w.acc = acc;
			w.accepts = acc_cnt;
			w.steps = step_cnt;
			w.pos_sum = pos_acc;
			w.sq_sum = sq_acc;
			pending.push_back(w);
		endfunction

		// Compare an output word with the oldest prediction
		function void check_output(logic [OUT_W-1:0] data);
			step_word_t got, want;
			got = data[216:0];
			if (pending.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %h", $realtime, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.pos !== want.pos) begin
				$display("%0t: position expected %0d actual %0d", $realtime, want.pos, got.pos);
				errors++;
			end
			if (got.acc !== want.acc) begin
				$display("%0t: accepted expected %0b actual %0b", $realtime, want.acc, got.acc);
				errors++;
			end
			if (got.accepts !== want.accepts) begin
				$display("%0t: accept_total expected %0d actual %0d", $realtime,
					want.accepts, got.accepts);
				errors++;
			end
			if (got.steps !== want.steps) begin
				$display("%0t: step_total expected %0d actual %0d", $realtime,
					want.steps, got.steps);
				errors++;
			end
			if (got.pos_sum !== want.pos_sum) begin
				$display("%0t: position_sum expected %h actual %h", $realtime,
					want.pos_sum, got.pos_sum);
				errors++;
			end
			if (got.sq_sum !== want.sq_sum) begin
				$display("%0t: square_sum expected %h actual %h", $realtime,
					want.sq_sum, got.sq_sum);
				errors++;
			end
			if (data[OUT_W-1:217] !== '0) begin
				$display("%0t: pad bits expected 0 actual %h", $realtime, data[OUT_W-1:217]);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_W-1:0]      m_tdata;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	step_scoreboard sb;
	int  idle_words;
	bit  calm;
	bit  hold_off;

	metropolis_sampler_step_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Note inputs, check outputs and count quiet cycles at each rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_input(s_tdata[15:0], s_tdata[31:16]);
			if (m_tvalid && m_tready)
				sb.check_output(m_tdata);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_words = 0;
			else
				idle_words++;
			if (idle_words >= WATCHDOG) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Drive the receiver with random stalls and one long hold-off
	initial begin
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_tready <= 0;
				repeat (300) @(negedge clk);
				hold_off = 0;
			end
			m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 16);
		end
	end

	// Offer one word; valid stays up after acceptance until the next call or drain
	task automatic send_word(logic [15:0] u_step, logic [15:0] u_test);
		while (!calm && $urandom_range(99) < 16) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {u_test, u_step};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// Drop valid, wait for every predicted word, then a latency margin, before a write
	task automatic drain();
		s_tvalid <= 0;
		@(negedge clk);
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_we <= 0;
		@(negedge clk);
	endtask

	task automatic random_setting();
		write_cfg(REG_STEP_HALF, ($urandom_range(3) == 0) ? 24'($urandom) :
			24'($urandom_range(1 << 19)));
		write_cfg(REG_OFFSET_A, ($urandom_range(4) == 0) ? 24'($urandom) :
			24'(-$urandom_range(10 << 16)));
		write_cfg(REG_OFFSET_B, ($urandom_range(4) == 0) ? 24'($urandom) :
			24'($urandom_range(10 << 16)));
		write_cfg(REG_INV_VAR_A, ($urandom_range(3) == 0) ? 24'($urandom) :
			24'($urandom_range(16384)));
		write_cfg(REG_INV_VAR_B, ($urandom_range(3) == 0) ? 24'($urandom) :
			24'($urandom_range(16384)));
		write_cfg(REG_INIT_POS, ($urandom_range(4) == 0) ? 24'($urandom) :
			24'($urandom_range(20 << 16) - (10 << 16)));
	endtask

	initial begin
		sb = new();
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = 0;
		idle_words = 0;
		calm = 0;
		hold_off = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: field extremes at reset settings
		send_word(16'h0000, 16'h0000);
		send_word(16'hFFFF, 16'hFFFF);
		send_word(16'h8000, 16'h0000);
		send_word(16'h0000, 16'hFFFF);
		send_word(16'hFFFF, 16'h0001);
		drain();
		// Saturation at both ends of the range with the widest step
		write_cfg(REG_STEP_HALF, 24'h7FFFFF);
		write_cfg(REG_INV_VAR_A, 24'd0);
		write_cfg(REG_INV_VAR_B, 24'd0);
		write_cfg(REG_INIT_POS, 24'h7FFFFF);
		send_word(16'hFFFF, 16'h0000);
		send_word(16'h0000, 16'h0000);
		drain();
		write_cfg(REG_INIT_POS, 24'h800000);
		send_word(16'h0000, 16'h0000);
		send_word(16'hFFFF, 16'h0000);
		drain();
		// Both densities zero: far away with narrow terms
		write_cfg(REG_INV_VAR_A, 24'hFFFF);
		write_cfg(REG_INV_VAR_B, 24'hFFFF);
		write_cfg(REG_OFFSET_A, 24'h800000);
		write_cfg(REG_OFFSET_B, 24'h7FFFFF);
		write_cfg(REG_STEP_HALF, 24'd16);
		write_cfg(REG_INIT_POS, 24'd0);
		send_word(16'h1234, 16'h0000);
		send_word(16'hFFFF, 16'hFFFF);
		drain();
		// Current density zero, proposal nonzero
		write_cfg(REG_OFFSET_A, 24'd0);
		write_cfg(REG_INV_VAR_A, 24'd4096);
		write_cfg(REG_STEP_HALF, 24'h7FFFFF);
		write_cfg(REG_INIT_POS, 24'h7FFFFF);
		send_word(16'h0000, 16'hFFFF);
		drain();
		// Index beyond the list and extra data bits
		write_cfg(3'd6, 24'hFFFFFF);
		write_cfg(3'd7, 24'h123456);
		write_cfg(REG_STEP_HALF, 24'hFFFFFF);
		write_cfg(REG_INV_VAR_B, 24'hFF1000);
		send_word(16'h4000, 16'h8000);
		send_word(16'hC000, 16'h0100);
		drain();

		// Random phases under changing settings
		for (int ph = 0; ph < 17; ph++) begin
			if (ph == 0) begin
				write_cfg(REG_STEP_HALF, 24'(RST_STEP_HALF));
				write_cfg(REG_OFFSET_A, 24'(RST_OFFSET_A));
				write_cfg(REG_OFFSET_B, 24'(RST_OFFSET_B));
				write_cfg(REG_INV_VAR_A, 24'(RST_INV_VAR));
				write_cfg(REG_INV_VAR_B, 24'(RST_INV_VAR));
			end else
				random_setting();
			calm = (ph == 3);
			if (ph == 5) hold_off = 1;
			for (int i = 0; i < 50; i++)
				send_word(16'($urandom), 16'($urandom));
			drain();
		end
		calm = 0;

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
